// ===== src/ncc_pkg.sv =====
package ncc_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_BASE = 2'd0;
  localparam logic [1:0] OP_EOS  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Result kinds carried on out_tuser
  localparam logic RES_SEGMENT = 1'b0;
  localparam logic RES_COUNTER = 1'b1;

  // Counter index map
  localparam logic [6:0] DI_BASE   = 7'd4;
  localparam logic [6:0] TRI_BASE  = 7'd20;
  localparam logic [6:0] TOT_BASE  = 7'd84;
  localparam logic [6:0] TOT_END   = 7'd89;

  localparam int MONO_DEPTH = 4;
  localparam int DI_DEPTH   = 16;
  localparam int TRI_DEPTH  = 64;

  // Totals
  localparam logic [2:0] TOT_MONO    = 3'd0;
  localparam logic [2:0] TOT_DI      = 3'd1;
  localparam logic [2:0] TOT_TRI     = 3'd2;
  localparam logic [2:0] TOT_SEG_CNT = 3'd3;
  localparam logic [2:0] TOT_SEG_SUM = 3'd4;

  localparam logic [7:0] CHAR_N_UP = 8'h4E;
  localparam logic [7:0] CHAR_N_LO = 8'h6E;

  // Read source select
  localparam logic [2:0] SEL_MONO = 3'd0;
  localparam logic [2:0] SEL_DI   = 3'd1;
  localparam logic [2:0] SEL_TRI  = 3'd2;
  localparam logic [2:0] SEL_TOT  = 3'd3;
  localparam logic [2:0] SEL_ZERO = 3'd4;

  localparam int VALUE_W    = 64;
  localparam int RES_W      = VALUE_W + 1;
  localparam int OFIFO_DEPTH = 4;
  localparam int LVL_W      = $clog2(OFIFO_DEPTH + 1);

  typedef struct packed {
    logic       valid;
    logic       inc_mono;
    logic       inc_di;
    logic       inc_tri;
    logic       emit;
    logic       rd;
    logic [2:0] rd_sel;
    logic [2:0] tot_idx;
  } s1_ctrl_t;

endpackage

// ===== src/ncc_bank.sv =====
module ncc_bank
  import ncc_pkg::*;
#(
  parameter int W     = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     inc,
  output logic [W-1:0]             q
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [W-1:0]  q_r;
  logic [W-1:0]  fwd_val_r;
  logic [AW-1:0] addr_r;
  logic [DEPTH-1:0] vld_r;
  logic          vld_q_r;
  logic          fwd_r;
  logic [W-1:0]  upd;

  // Take the value written at the read edge over stale memory data
  always_comb begin
    if (fwd_r) begin
      q = fwd_val_r;
    end else if (vld_q_r) begin
      q = q_r;
    end else begin
      q = '0;
    end
  end

  assign upd = q + W'(1);

  always_ff @(posedge clk) begin
    q_r <= mem[rd_addr];
    if (inc) begin
      mem[addr_r] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= rd_addr;
    fwd_val_r <= upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      vld_q_r <= vld_r[rd_addr];
      fwd_r   <= inc && (addr_r == rd_addr);
      if (inc) begin
        vld_r[addr_r] <= 1'b1;
      end
    end
  end

endmodule

// ===== src/ncc_ofifo.sv =====
module ncc_ofifo
  import ncc_pkg::*;
#(
  parameter int W     = 65,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output logic [W-1:0]               pop_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  buf_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] level_r;
  logic          pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (level_r != '0);
  assign pop_data  = buf_r[rd_ptr_r];
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + CW'(1);
      end else if (pop && !push) begin
        level_r <= level_r - CW'(1);
      end
    end
  end

endmodule

// ===== src/nucleotide_composition_counter_top.sv =====
// Nucleotide composition counter.
// Input channel (in_*): one transaction per item. in_tuser is the operation:
// a base character, end of sequence, or a counter read. Each base bumps one
// mono, one di (from the second base) and one tri counter (from the third),
// plus the running totals. End of sequence, and in split mode an N base,
// closes a segment and returns its length. A read returns one counter.
// Result channel (out_*): out_tuser says segment length or counter data,
// out_tdata carries the value. cfg_we/cfg_wdata write split_at_n; write it
// only while no transaction is in flight.
// A result passes the stage-1 register and then the output queue before it is
// offered on out_*.
// Throughput: one item per cycle while in_tready is high; the mono, di and
// tri counters each live in a one-read/one-write memory updated
// read-modify-write, with the value just written forwarded to a back-to-back
// hit on the same entry. Reset: all counters read as zero right away
// (per-entry valid bits), no clearing pass. When out_tready is low, results
// collect in a four-entry output queue; in_tready drops only when the queue
// could not take the results still in the pipeline.
module nucleotide_composition_counter_top
  import ncc_pkg::*;
#(
  parameter int COUNT_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] base_char, [14:8] counter_index, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic [0:0]  out_tuser,  // [0] result_kind
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam int CNT_W = COUNT_WIDTH;

  logic             split_r;
  logic [3:0]       recent_r, recent_nxt;
  logic [1:0]       bis_r, bis_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  s1_ctrl_t         s1_r, s1_nxt;
  logic [CNT_W-1:0] seg_len_r, seg_len_nxt;

  logic [CNT_W-1:0] tot_mono_r, tot_di_r, tot_tri_r, seg_cnt_r, seg_sum_r;

  logic       acc;
  logic [1:0] op;
  logic [7:0] ch;
  logic [6:0] idx;
  logic [1:0] code;
  logic       is_n;
  logic [6:0] idx_di, idx_tri, idx_tot;

  logic [1:0] mono_addr;
  logic [3:0] di_addr;
  logic [5:0] tri_addr;
  logic [CNT_W-1:0] mono_q, di_q, tri_q, rd_val;

  logic             push;
  logic [RES_W-1:0] push_data;
  logic [RES_W-1:0] pop_data;
  logic [LVL_W-1:0] fifo_level;

  assign acc  = in_tvalid && in_tready;
  assign op   = in_tuser;
  assign ch   = in_tdata[7:0];
  assign idx  = in_tdata[14:8];
  assign code = ch[2:1];
  assign is_n = (ch == CHAR_N_UP) || (ch == CHAR_N_LO);

  assign idx_di  = idx - DI_BASE;
  assign idx_tri = idx - TRI_BASE;
  assign idx_tot = idx - TOT_BASE;

  // Reads address by counter index, bases by the k-mer ending in this code
  always_comb begin
    if (op == OP_READ) begin
      mono_addr = idx[1:0];
      di_addr   = idx_di[3:0];
      tri_addr  = idx_tri[5:0];
    end else begin
      mono_addr = code;
      di_addr   = {recent_r[1:0], code};
      tri_addr  = {recent_r, code};
    end
  end

  // Sequence tracking and stage-1 control
  always_comb begin
    recent_nxt  = recent_r;
    bis_nxt     = bis_r;
    run_nxt     = run_r;
    s1_nxt      = '0;
    seg_len_nxt = run_r;
    if (acc) begin
      s1_nxt.valid = 1'b1;
      case (op)
        OP_BASE: begin
          s1_nxt.inc_mono = 1'b1;
          s1_nxt.inc_di   = (bis_r != 2'd0);
          s1_nxt.inc_tri  = (bis_r == 2'd2);
          recent_nxt      = {recent_r[1:0], code};
          if (bis_r != 2'd2) begin
            bis_nxt = bis_r + 2'd1;
          end
          if (split_r && is_n) begin
            s1_nxt.emit = (run_r != '0);
            run_nxt     = '0;
          end else begin
            run_nxt = run_r + CNT_W'(1);
          end
        end
        OP_EOS: begin
          s1_nxt.emit = !(split_r && (run_r == '0));
          run_nxt     = '0;
          bis_nxt     = 2'd0;
        end
        OP_READ: begin
          s1_nxt.rd      = 1'b1;
          s1_nxt.tot_idx = idx_tot[2:0];
          if (idx < DI_BASE) begin
            s1_nxt.rd_sel = SEL_MONO;
          end else if (idx inside {[DI_BASE:TRI_BASE-7'd1]}) begin
            s1_nxt.rd_sel = SEL_DI;
          end else if (idx inside {[TRI_BASE:TOT_BASE-7'd1]}) begin
            s1_nxt.rd_sel = SEL_TRI;
          end else if (idx inside {[TOT_BASE:TOT_END-7'd1]}) begin
            s1_nxt.rd_sel = SEL_TOT;
          end else begin
            s1_nxt.rd_sel = SEL_ZERO;
          end
        end
        default: begin
          s1_nxt.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r  <= 1'b0;
      recent_r <= '0;
      bis_r    <= '0;
      run_r    <= '0;
      s1_r     <= '0;
    end else begin
      if (cfg_we) begin
        split_r <= cfg_wdata;
      end
      recent_r <= recent_nxt;
      bis_r    <= bis_nxt;
      run_r    <= run_nxt;
      s1_r     <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_len_r <= seg_len_nxt;
  end

  ncc_bank #(.W(CNT_W), .DEPTH(MONO_DEPTH)) u_mono (
    .clk(clk), .rst_n(rst_n), .rd_addr(mono_addr), .inc(s1_r.inc_mono), .q(mono_q)
  );

  ncc_bank #(.W(CNT_W), .DEPTH(DI_DEPTH)) u_di (
    .clk(clk), .rst_n(rst_n), .rd_addr(di_addr), .inc(s1_r.inc_di), .q(di_q)
  );

  ncc_bank #(.W(CNT_W), .DEPTH(TRI_DEPTH)) u_tri (
    .clk(clk), .rst_n(rst_n), .rd_addr(tri_addr), .inc(s1_r.inc_tri), .q(tri_q)
  );

  // Running totals advance in stage 1, alongside the memory writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_mono_r <= '0;
      tot_di_r   <= '0;
      tot_tri_r  <= '0;
      seg_cnt_r  <= '0;
      seg_sum_r  <= '0;
    end else begin
      if (s1_r.inc_mono) begin
        tot_mono_r <= tot_mono_r + CNT_W'(1);
      end
      if (s1_r.inc_di) begin
        tot_di_r <= tot_di_r + CNT_W'(1);
      end
      if (s1_r.inc_tri) begin
        tot_tri_r <= tot_tri_r + CNT_W'(1);
      end
      if (s1_r.emit) begin
        seg_cnt_r <= seg_cnt_r + CNT_W'(1);
        seg_sum_r <= seg_sum_r + seg_len_r;
      end
    end
  end

  always_comb begin
    case (s1_r.rd_sel)
      SEL_MONO: rd_val = mono_q;
      SEL_DI:   rd_val = di_q;
      SEL_TRI:  rd_val = tri_q;
      SEL_TOT: begin
        case (s1_r.tot_idx)
          TOT_MONO:    rd_val = tot_mono_r;
          TOT_DI:      rd_val = tot_di_r;
          TOT_TRI:     rd_val = tot_tri_r;
          TOT_SEG_CNT: rd_val = seg_cnt_r;
          TOT_SEG_SUM: rd_val = seg_sum_r;
          default:     rd_val = '0;
        endcase
      end
      default: rd_val = '0;
    endcase
  end

  assign push = s1_r.valid && (s1_r.emit || s1_r.rd);

  always_comb begin
    if (s1_r.rd) begin
      push_data = {VALUE_W'(rd_val), RES_COUNTER};
    end else begin
      push_data = {VALUE_W'(seg_len_r), RES_SEGMENT};
    end
  end

  // Hold off input unless the queue can absorb what stage 1 may still push
  assign in_tready = (fifo_level + LVL_W'(push)) < LVL_W'(OFIFO_DEPTH);

  ncc_ofifo #(.W(RES_W), .DEPTH(OFIFO_DEPTH)) u_ofifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_data(push_data),
    .pop_valid(out_tvalid),
    .pop_ready(out_tready),
    .pop_data(pop_data),
    .level(fifo_level)
  );

  assign out_tuser = pop_data[0:0];
  assign out_tdata = pop_data[RES_W-1:1];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !(out_tvalid && out_tready)) |-> (fifo_level != LVL_W'(OFIFO_DEPTH)))
    else $error("result queue overflow");

  a_eos_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_EOS) && !split_r) |=> push)
    else $error("end of sequence without segment result");

  a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == OP_READ)) |=> (push && s1_r.rd))
    else $error("counter read without result");

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_r.rd && (s1_r.emit || s1_r.inc_mono)))
    else $error("read and update in the same transaction");

endmodule
